/* sv/ccw_pkg.sv */
// Shared types, constants and tables for the text console character writer.
// Depends on nothing; ccw_cursor, ccw_cell, the core and the testbench import it.
package ccw_pkg;

	// Screen geometry
	localparam int COLUMNS = 64;
	localparam int ROWS    = 32;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);

	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);

	// Field widths
	localparam int CH_W     = 8;
	localparam int COLOUR_W = 24;
	localparam int EPOCH_W  = 32;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 72;
	localparam int OUT_PAD  = OUT_W - 68;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	// Item kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_POS  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Control characters
	localparam logic [CH_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CH_W-1:0] CH_LINEFEED  = 8'd10;
	localparam logic [CH_W-1:0] CH_SPACE     = 8'd32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_FORE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BACK = 8'd1;

	localparam logic [COLOUR_W-1:0] LINE_FORE_RST = 24'h00FF00;
	localparam logic [COLOUR_W-1:0] LINE_BACK_RST = 24'h181818;

	// One screen cell as stored; tag is the row epoch at the time of writing
	typedef struct packed {
		logic [EPOCH_W-1:0]  tag;
		logic [CH_W-1:0]     ch;
		logic [COLOUR_W-1:0] fore;
		logic [COLOUR_W-1:0] back;
	} cell_t;

	// Per physical row: epoch of the last clear and its fill colours
	typedef struct packed {
		logic [EPOCH_W-1:0]  epoch;
		logic [COLOUR_W-1:0] fore;
		logic [COLOUR_W-1:0] back;
	} row_t;

	// Item handed from the cursor stage to the cell stage
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [CH_W-1:0]   ch;
		logic [ADDR_W-1:0] addr;
		logic [5:0]        col;
		logic [4:0]        row;
		logic              scrolled;
	} item_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		cell_t             data;
	} cell_wr_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] addr;
		row_t             data;
	} row_wr_t;

	// Modulo tables for the 8-bit row and column fields
	typedef logic [ROW_W-1:0] row_tab_t [256];
	typedef logic [COL_W-1:0] col_tab_t [256];

	function automatic row_tab_t build_row_mod();
		row_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = ROW_W'(i % ROWS);
		end
		return tab;
	endfunction

	function automatic col_tab_t build_col_mod();
		col_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = COL_W'(i % COLUMNS);
		end
		return tab;
	endfunction

	localparam row_tab_t ROW_MOD = build_row_mod();
	localparam col_tab_t COL_MOD = build_col_mod();

endpackage

/* sv/ccw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ccw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/ccw_cursor.sv */
// Cursor stage: cursor, top-row ring pointer and scroll epoch; issues memory reads.
// Depends on ccw_pkg.
module ccw_cursor import ccw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [1:0]          kind,
	input  logic [CH_W-1:0]     ch,
	input  logic [7:0]          row,
	input  logic [7:0]          col,
	input  logic [COLOUR_W-1:0] line_fore,
	input  logic [COLOUR_W-1:0] line_back,
	output item_t               item,
	output logic [ROW_W-1:0]    row_raddr,
	output row_wr_t             row_wr
);

	logic [COL_W-1:0]   cur_x_q;
	logic [ROW_W-1:0]   cur_y_q;
	logic [ROW_W-1:0]   top_q;
	logic [EPOCH_W-1:0] epoch_q;

	logic [ROW_W-1:0] r_mod, by, ny, sel_row, prow;
	logic [COL_W-1:0] c_mod, bx, nx, sel_col;
	logic             active, down, scroll, store;
	logic [ROW_W:0]   psum;
	logic [ADDR_W-1:0] addr;

	// Cursor update for one item
	always_comb begin
		r_mod  = ROW_MOD[row];
		c_mod  = COL_MOD[col];
		bx     = (kind == KIND_POS) ? c_mod : cur_x_q;
		by     = (kind == KIND_POS) ? r_mod : cur_y_q;
		active = (kind == KIND_CHAR) || (kind == KIND_POS);
		nx     = bx;
		ny     = by;
		down   = 1'b0;
		store  = 1'b0;
		scroll = 1'b0;
		if (active) begin
			case (ch)
				CH_RETURN: nx = '0;
				CH_BACKSPACE: begin
					if (bx != '0) begin
						nx = bx - COL_W'(1);
					end else if (by != '0) begin
						ny = by - ROW_W'(1);
						nx = COL_LAST;
					end
				end
				CH_LINEFEED: down = 1'b1;
				default: begin
					store = 1'b1;
					if (bx == COL_LAST) begin
						nx   = '0;
						down = 1'b1;
					end else begin
						nx = bx + COL_W'(1);
					end
				end
			endcase
		end
		if (down) begin
			if (by == ROW_LAST) begin
				scroll = 1'b1;
			end else begin
				ny = by + ROW_W'(1);
			end
		end
	end

	// Logical to physical cell address through the ring pointer
	always_comb begin
		sel_row = (kind == KIND_READ) ? r_mod : by;
		sel_col = (kind == KIND_READ) ? c_mod : bx;
		psum    = {1'b0, top_q} + {1'b0, sel_row};
		if (psum >= (ROW_W + 1)'(ROWS)) begin
			psum = psum - (ROW_W + 1)'(ROWS);
		end
		prow = psum[ROW_W-1:0];
		addr = ADDR_W'(prow) * COLS_A + ADDR_W'(sel_col);
	end

	// Outputs to the memories and the cell stage
	always_comb begin
		row_raddr       = prow;
		item.rd         = (kind == KIND_READ);
		item.wr         = store;
		item.ch         = ch;
		item.addr       = addr;
		item.col        = 6'(nx);
		item.row        = 5'(ny);
		item.scrolled   = scroll;
		row_wr.en       = en && scroll;
		row_wr.addr     = top_q;
		row_wr.data     = '{epoch: epoch_q + EPOCH_W'(1), fore: line_fore, back: line_back};
	end

	// Cursor, ring pointer and epoch registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			top_q   <= '0;
			epoch_q <= '0;
		end else if (en) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			if (scroll) begin
				top_q   <= (top_q == ROW_LAST) ? '0 : top_q + ROW_W'(1);
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
		end
	end

endmodule

/* sv/ccw_cell.sv */
// Cell stage: resolves cleared rows, forwards the last write, stores characters
// and holds the result register. Depends on ccw_pkg.
module ccw_cell import ccw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  item_t            in_item,
	output logic             in_ready,
	input  cell_t            cell_rdata,
	input  row_t             row_rdata,
	output cell_wr_t         cell_wr,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic     valid_s1;
	item_t    item_s1;
	logic     fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	cell_t    fwd_data_q;
	logic     out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic  adv;
	cell_t src, cur;
	logic [CH_W-1:0]     r_ch;
	logic [COLOUR_W-1:0] r_fore, r_back;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Pick the newest copy of the cell, then replace stale cells by the row fill
	always_comb begin
		src = (fwd_valid_q && (fwd_addr_q == item_s1.addr)) ? fwd_data_q : cell_rdata;
		if (src.tag == row_rdata.epoch) begin
			cur = src;
		end else begin
			cur = '{tag: row_rdata.epoch, ch: CH_SPACE, fore: row_rdata.fore,
				back: row_rdata.back};
		end
		cell_wr.en   = adv && item_s1.wr;
		cell_wr.addr = item_s1.addr;
		cell_wr.data = '{tag: row_rdata.epoch, ch: item_s1.ch, fore: cur.fore,
			back: cur.back};
		r_ch   = item_s1.rd ? cur.ch : '0;
		r_fore = item_s1.rd ? cur.fore : '0;
		r_back = item_s1.rd ? cur.back : '0;
	end

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Forwarding register: last cell write, not yet visible to a read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (cell_wr.en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_wr.en) begin
			fwd_addr_q <= cell_wr.addr;
			fwd_data_q <= cell_wr.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {{OUT_PAD{1'b0}}, r_back, r_fore, r_ch, item_s1.scrolled,
				item_s1.row, item_s1.col};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* sv/text_console_char_writer_core.sv */
// Top level of the text console character writer: config registers, clearing
// pass, cell and row memories. Depends on ccw_pkg, ccw_ram, ccw_cursor, ccw_cell.
//
// Usage:
//   s_* carries input items: kind in s_tuser, character, row and column in s_tdata.
//   m_* carries one result per accepted item, in order.
//   cfg_* writes the line fill colours; take it only while the block is idle.
// Path: an item is registered in the cell stage, then in the result register.
// Throughput: one item per cycle while m_tready keeps up and no clearing pass runs.
//   The cell memory is read in the accept cycle and written back as the item leaves
//   the cell stage; a one-entry forwarding register covers the overlap.
//   Scrolling moves a ring pointer and stamps the freed row with a new epoch.
// Reset: cursor at the origin, colours to their defaults, then a clearing pass over
//   all ROWS*COLUMNS cells (2048 at 64x32) zeroes the memories; s_tready stays low
//   meanwhile. Config writes are taken during the pass.
// Back-pressure: when m_tready is low the result waits in its register; one more
//   item is taken into the cell stage, then s_tready drops until the result leaves.
module text_console_char_writer_core import ccw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,    // ch[7:0], row[15:8], col[23:16]
	input  logic [1:0]           s_tuser,    // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cursor_col[5:0], cursor_row[10:6], scrolled[11], cell_char[19:12],
	// cell_fore[43:20], cell_back[67:44], zero[71:68]
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [COLOUR_W-1:0] line_fore_q, line_back_q;
	logic                clr_busy_q;
	logic [ADDR_W-1:0]   clr_cnt_q;

	logic     accept, s1_ready;
	item_t    item;
	logic [ROW_W-1:0] row_raddr;
	row_wr_t  row_wr_op, row_wr;
	cell_wr_t cell_wr_op, cell_wr;
	cell_t    cell_rdata;
	row_t     row_rdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = !clr_busy_q && s1_ready;
	assign accept    = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_fore_q <= LINE_FORE_RST;
			line_back_q <= LINE_BACK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINE_FORE: line_fore_q <= cfg_data[COLOUR_W-1:0];
				REG_LINE_BACK: line_back_q <= cfg_data[COLOUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Write port selection: clearing pass or live traffic
	always_comb begin
		if (clr_busy_q) begin
			cell_wr.en   = 1'b1;
			cell_wr.addr = clr_cnt_q;
			cell_wr.data = '0;
			row_wr.en    = (clr_cnt_q < ADDR_W'(ROWS));
			row_wr.addr  = clr_cnt_q[ROW_W-1:0];
			row_wr.data  = '0;
		end else begin
			cell_wr = cell_wr_op;
			row_wr  = row_wr_op;
		end
	end

	ccw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.kind      (s_tuser),
		.ch        (s_tdata[7:0]),
		.row       (s_tdata[15:8]),
		.col       (s_tdata[23:16]),
		.line_fore (line_fore_q),
		.line_back (line_back_q),
		.item      (item),
		.row_raddr (row_raddr),
		.row_wr    (row_wr_op)
	);

	ccw_ram #(
		.WIDTH ($bits(cell_t)),
		.DEPTH (CELLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_wr.en),
		.waddr (cell_wr.addr),
		.wdata (cell_wr.data),
		.re    (accept),
		.raddr (item.addr),
		.rdata (cell_rdata)
	);

	ccw_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (ROWS)
	) u_row_ram (
		.clk   (clk),
		.we    (row_wr.en),
		.waddr (row_wr.addr),
		.wdata (row_wr.data),
		.re    (accept),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	ccw_cell u_cell (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_item    (item),
		.in_ready   (s1_ready),
		.cell_rdata (cell_rdata),
		.row_rdata  (row_rdata),
		.cell_wr    (cell_wr_op),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench for text_console_char_writer_core: a cycle-free console model
// predicts every result; directed, line-colour and random traffic tests drive the streams.
// Depends on ccw_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
	import ccw_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PRINT_LIMIT = 40;

	// One stored screen cell and one console result as the block reports it
	typedef struct packed {
		logic [7:0]  ch;
		logic [23:0] fore;
		logic [23:0] back;
	} screen_cell_t;

	typedef struct packed {
		logic [5:0]  col;
		logic [4:0]  row;
		logic        scrolled;
		logic [7:0]  ch;
		logic [23:0] fore;
		logic [23:0] back;
	} console_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	text_console_char_writer_core dut (.*);

	// Console state mirror
	screen_cell_t    screen [ROWS*COLUMNS];
	int unsigned     cur_x, cur_y;
	logic [23:0]     fill_fore, fill_back;
	console_result_t results_due [$];
	int              error_count = 0;

	// Sender burst and receiver stall state
	int tx_burst_left = 0;
	int tx_max_gap = 4;
	int rx_mode = 0;
	int rx_mode_cycles = 0;
	int rx_phase = 0;
	int idle_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("%0t mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Move the mirror cursor down a row, scrolling when it leaves the last row
	function automatic bit next_line();
		if (cur_y + 1 >= ROWS) begin
			for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = 0; i < COLUMNS; i++)
				screen[(ROWS - 1) * COLUMNS + i] = '{CH_SPACE, fill_fore, fill_back};
			cur_y = ROWS - 1;
			return 1'b1;
		end
		cur_y++;
		return 1'b0;
	endfunction

	function automatic bit put_glyph(input logic [7:0] c);
		if (c == CH_RETURN) begin
			cur_x = 0;
		end else if (c == CH_BACKSPACE) begin
			if (cur_x > 0) begin
				cur_x--;
			end else if (cur_y > 0) begin
				cur_y--;
				cur_x = COLUMNS - 1;
			end
		end else if (c == CH_LINEFEED) begin
			return next_line();
		end else begin
			screen[cur_y * COLUMNS + cur_x].ch = c;
			cur_x++;
			if (cur_x >= COLUMNS) begin
				cur_x = 0;
				return next_line();
			end
		end
		return 1'b0;
	endfunction

	function automatic console_result_t console_predict(input logic [1:0] kind,
			input logic [7:0] ch, input logic [7:0] row, input logic [7:0] col);
		console_result_t res;
		int unsigned r, k;
		bit sc;
		res = '0;
		sc = 1'b0;
		r = row % ROWS;
		k = col % COLUMNS;
		case (kind)
			KIND_CHAR: sc = put_glyph(ch);
			KIND_POS: begin
				cur_x = k;
				cur_y = r;
				sc = put_glyph(ch);
			end
			KIND_READ: begin
				res.ch   = screen[r * COLUMNS + k].ch;
				res.fore = screen[r * COLUMNS + k].fore;
				res.back = screen[r * COLUMNS + k].back;
			end
			default: ;
		endcase
		res.col = cur_x[5:0];
		res.row = cur_y[4:0];
		res.scrolled = sc;
		return res;
	endfunction

	// Send one item; bursts of back-to-back transactions separated by random gaps
	task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
			input logic [7:0] row, input logic [7:0] col);
		int gap;
		@(negedge clk);
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, tx_max_gap);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		tx_burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {col, row, ch};
		do @(posedge clk); while (!s_tready);
		results_due.push_back(console_predict(kind, ch, row, col));
	endtask

	task automatic park_sender();
		@(negedge clk);
		s_tvalid <= 1'b0;
		tx_burst_left = 0;
	endtask

	// Register writes only once every result has come back
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] value);
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_LINE_FORE)
			fill_fore = value[23:0];
		else if (idx == REG_LINE_BACK)
			fill_back = value[23:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_line_colours(input logic [CFG_DAT_W-1:0] fore,
			input logic [CFG_DAT_W-1:0] back);
		park_sender();
		write_register(REG_LINE_FORE, fore);
		write_register(REG_LINE_BACK, back);
		// an index past the two registers must change nothing
		write_register(REG_LINE_BACK + CFG_IDX_W'($urandom_range(1, 254)), $urandom);
	endtask

	function automatic logic [7:0] random_char();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) return CH_RETURN;
		if (sel < 20) return CH_BACKSPACE;
		if (sel < 35) return CH_LINEFEED;
		return 8'($urandom_range(0, 255));
	endfunction

	// Edges of the cursor motion, the modulo fields, the unused kind, reads at reset
	task automatic test_directed();
		send_item(KIND_READ, 8'd0, 8'd0, 8'd0);
		send_item(KIND_CHAR, 8'h41, 8'd0, 8'd0);
		send_item(KIND_CHAR, 8'hFF, 8'd0, 8'd0);
		send_item(KIND_CHAR, 8'h00, 8'd0, 8'd0);
		send_item(KIND_READ, 8'd0, 8'd0, 8'd0);
		send_item(KIND_READ, 8'd0, 8'd0, 8'd1);
		send_item(KIND_CHAR, CH_BACKSPACE, 8'd0, 8'd0);
		send_item(KIND_CHAR, CH_RETURN, 8'd0, 8'd0);
		send_item(KIND_CHAR, CH_BACKSPACE, 8'd0, 8'd0);
		send_item(KIND_POS, CH_BACKSPACE, 8'd1, 8'd0);
		send_item(KIND_POS, 8'h5A, 8'hFF, 8'hFF);
		send_item(KIND_READ, 8'd0, 8'd31, 8'd0);
		send_item(KIND_READ, 8'd0, 8'd30, 8'd63);
		send_item(KIND_CHAR, CH_LINEFEED, 8'd0, 8'd0);
		send_item(KIND_POS, CH_LINEFEED, 8'd5, 8'd10);
		send_item(KIND_POS, CH_LINEFEED, 8'd31, 8'd17);
		send_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		send_item(KIND_READ, 8'hFF, 8'hFF, 8'hFF);
		send_item(KIND_POS, CH_RETURN, 8'd0, 8'd0);
		send_item(KIND_READ, 8'd0, 8'd0, 8'd0);
		send_item(KIND_READ, 8'd0, 8'd29, 8'd63);
	endtask

	// Scroll under several line colour settings; read the new bottom row and the row above
	task automatic test_line_colours();
		logic [CFG_DAT_W-1:0] fores [3];
		logic [CFG_DAT_W-1:0] backs [3];
		fores = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom};
		backs = '{32'hFF00_0000, 32'h00FF_FFFF, $urandom};
		for (int i = 0; i < 3; i++) begin
			set_line_colours(fores[i], backs[i]);
			send_item(KIND_POS, CH_LINEFEED, 8'd31, 8'($urandom_range(0, 255)));
			send_item(KIND_READ, 8'd0, 8'd31, 8'd0);
			send_item(KIND_READ, 8'd0, 8'd31, 8'd63);
			send_item(KIND_READ, 8'd0, 8'd30, 8'($urandom_range(0, 255)));
		end
	endtask

	// Mixed traffic: typing, positioning, reads near the cursor, scroll runs, noise
	task automatic test_random_traffic(input int count);
		int done;
		int sel;
		int runs;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_line_colours(32'h0000_0000, 32'h00FF_FFFF);
				1: set_line_colours(32'hFFFF_FFFF, 32'h0000_0000);
				default: set_line_colours($urandom, $urandom);
			endcase
			tx_max_gap = (phase == 2) ? 0 : $urandom_range(1, 8);
			done = 0;
			while (done < count / 5) begin
				sel = $urandom_range(0, 99);
				if (sel < 38) begin
					send_item(KIND_CHAR, random_char(), 8'($urandom), 8'($urandom));
					done++;
				end else if (sel < 53) begin
					send_item(KIND_POS, random_char(), 8'($urandom), 8'($urandom));
					done++;
				end else if (sel < 70) begin
					send_item(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom));
					done++;
				end else if (sel < 85) begin
					// read the cell just behind the cursor, folded by the modulo
					send_item(KIND_READ, 8'($urandom),
						8'(cur_y + ROWS * $urandom_range(0, 7)),
						8'((cur_x + COLUMNS - 1) % COLUMNS + COLUMNS * $urandom_range(0, 3)));
					done++;
				end else if (sel < 95) begin
					// type near the bottom, then feed lines that may scroll
					send_item(KIND_POS, 8'($urandom_range(33, 126)),
						8'(ROWS - 1 - $urandom_range(0, 2)), 8'($urandom));
					runs = $urandom_range(1, 5);
					for (int i = 0; i < runs; i++)
						send_item(KIND_CHAR, CH_LINEFEED, 8'($urandom), 8'($urandom));
					done += runs + 1;
				end else begin
					send_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
				end
			end
		end
	endtask

	task automatic finish_run();
		park_sender();
		while (results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (results_due.size() != 0)
			flag_mismatch("results still due at the end");
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	endtask

	// Main sequence
	initial begin
		fill_fore = LINE_FORE_RST;
		fill_back = LINE_BACK_RST;
		cur_x = 0;
		cur_y = 0;
		for (int i = 0; i < ROWS * COLUMNS; i++)
			screen[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_line_colours();
		test_random_traffic(1200);
		finish_run();
	end

	// Result stall pattern, switching mode at random among four patterns
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_cycles == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_cycles = $urandom_range(16, 200);
			end
			rx_mode_cycles--;
			rx_phase = (rx_phase + 1) % 7;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= (rx_phase >= 3);
				default: m_tready <= $urandom_range(0, 1);
			endcase
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		console_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[5:0], m_tdata[10:6], m_tdata[11], m_tdata[19:12],
				m_tdata[43:20], m_tdata[67:44]};
			if (results_due.size() == 0) begin
				flag_mismatch("result with none due");
			end else begin
				want = results_due.pop_front();
				if (got.col != want.col)
					flag_mismatch($sformatf("cursor_col %0d, want %0d", got.col, want.col));
				if (got.row != want.row)
					flag_mismatch($sformatf("cursor_row %0d, want %0d", got.row, want.row));
				if (got.scrolled != want.scrolled)
					flag_mismatch($sformatf("scrolled %0d, want %0d",
						got.scrolled, want.scrolled));
				if (got.ch != want.ch)
					flag_mismatch($sformatf("cell_char %h, want %h", got.ch, want.ch));
				if (got.fore != want.fore)
					flag_mismatch($sformatf("cell_fore %h, want %h", got.fore, want.fore));
				if (got.back != want.back)
					flag_mismatch($sformatf("cell_back %h, want %h", got.back, want.back));
			end
		end
	end

	// Watchdog: cycles without any transaction on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

/* filelist.f */
sv/ccw_pkg.sv
sv/ccw_ram.sv
sv/ccw_cursor.sv
sv/ccw_cell.sv
sv/text_console_char_writer_core.sv
tb/tb.sv
